// File: hw/rtl/rws_pkg.sv
// Package for the roulette wheel selector.
// Holds sizes, request kinds, controller states and the structs shared by the RTL modules.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package rws_pkg;

	localparam int MAX_POP = 64;
	localparam int IDX_W   = $clog2(MAX_POP);
	localparam int CNT_W   = IDX_W + 1;
	localparam int KIND_W  = 2;
	localparam int FIT_W   = 16;
	localparam int FRAC_W  = 16;
	localparam int SUM_W   = FIT_W + IDX_W;
	localparam int TGT_W   = SUM_W + FRAC_W;

	typedef enum logic [KIND_W-1:0] {
		KIND_CLEAR  = 2'd0,
		KIND_APPEND = 2'd1,
		KIND_SPIN   = 2'd2
	} rws_kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_READ,
		ST_CMP,
		ST_DONE
	} rws_state_t;

	typedef struct packed {
		logic [IDX_W-1:0] index;
		logic             empty;
		logic             overflow;
	} rws_result_t;

	typedef struct packed {
		logic             searching;
		logic [IDX_W-1:0] lo;
		logic [IDX_W-1:0] hi;
		logic [CNT_W-1:0] count;
	} rws_status_t;

endpackage

`default_nettype wire

// File: hw/rtl/rws_store.sv
// Prefix-sum store of the roulette wheel selector: one write port, one read port.
// Read data is registered, so it appears in the cycle after the read request.
// Depends on rws_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rws_store
	import rws_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [IDX_W-1:0] wr_addr,
	input  wire logic [SUM_W-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [IDX_W-1:0] rd_addr,
	output logic      [SUM_W-1:0] rd_data
);

	logic [SUM_W-1:0] mem [MAX_POP];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/rws_engine.sv
// Controller of the roulette wheel selector: population count, running total,
// overflow flag, appends into the prefix store and the binary search of a spin.
// Depends on rws_pkg and drives the ports of rws_store.
`timescale 1ns / 1ps
`default_nettype none

module rws_engine
	import rws_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_stall,
	input  wire logic [KIND_W-1:0] kind,
	input  wire logic [FIT_W-1:0]  fitness,
	input  wire logic [FRAC_W-1:0] random_fraction,
	output logic                   res_valid,
	input  wire logic              res_stall,
	output rws_result_t            res,
	output rws_status_t            status,
	output logic                   wr_en,
	output logic      [IDX_W-1:0]  wr_addr,
	output logic      [SUM_W-1:0]  wr_data,
	output logic                   rd_en,
	output logic      [IDX_W-1:0]  rd_addr,
	input  wire logic [SUM_W-1:0]  rd_data
);

	rws_state_t       state_q, state_d;
	logic [CNT_W-1:0] count_q;
	logic [SUM_W-1:0] total_q;
	logic             ovf_q;
	logic [FRAC_W-1:0] frac_q;
	logic [TGT_W-1:0] target_q;
	logic [IDX_W-1:0] lo_q, hi_q, lo_d, hi_d, mid;
	logic             empty_q;
	logic             accept, full, hit;
	rws_kind_t        req_kind;

	assign req_kind  = rws_kind_t'(kind);
	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && (state_q == ST_IDLE);
	assign full      = (count_q >= CNT_W'(MAX_POP));
	assign mid       = IDX_W'(({1'b0, lo_q} + {1'b0, hi_q}) >> 1);
	assign hit       = ({rd_data, FRAC_W'(0)} >= target_q);

	assign wr_en   = accept && (req_kind == KIND_APPEND) && !full;
	assign wr_addr = count_q[IDX_W-1:0];
	assign wr_data = total_q + SUM_W'(fitness);
	assign rd_en   = (state_q == ST_READ);
	assign rd_addr = mid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		lo_d    = lo_q;
		hi_d    = hi_q;
		if (hit) begin
			hi_d = mid;
		end else begin
			lo_d = mid + IDX_W'(1);
		end
		case (state_q)
			ST_IDLE: begin
				if (accept && (req_kind == KIND_SPIN)) begin
					state_d = (count_q == '0) ? ST_DONE : ST_MUL;
				end
			end
			ST_MUL: begin
				state_d = (lo_q == hi_q) ? ST_DONE : ST_READ;
			end
			ST_READ: begin
				state_d = ST_CMP;
			end
			ST_CMP: begin
				state_d = (lo_d == hi_d) ? ST_DONE : ST_READ;
			end
			ST_DONE: begin
				if (!res_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			total_q <= '0;
			ovf_q   <= 1'b0;
		end else if (accept) begin
			case (req_kind)
				KIND_CLEAR: begin
					count_q <= '0;
					total_q <= '0;
					ovf_q   <= 1'b0;
				end
				KIND_APPEND: begin
					if (full) begin
						ovf_q <= 1'b1;
					end else begin
						total_q <= wr_data;
						count_q <= count_q + CNT_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (req_kind == KIND_SPIN)) begin
			frac_q  <= random_fraction;
			lo_q    <= '0;
			hi_q    <= IDX_W'(count_q - CNT_W'(1));
			empty_q <= (count_q == '0);
		end else if (state_q == ST_CMP) begin
			lo_q <= lo_d;
			hi_q <= hi_d;
		end
		if (state_q == ST_MUL) begin
			target_q <= TGT_W'(total_q) * TGT_W'(frac_q);
		end
	end

	assign res_valid      = (state_q == ST_DONE);
	assign res.index      = empty_q ? '0 : lo_q;
	assign res.empty      = empty_q;
	assign res.overflow   = ovf_q;

	assign status.searching = (state_q == ST_MUL) || (state_q == ST_READ) ||
		(state_q == ST_CMP);
	assign status.lo        = lo_q;
	assign status.hi        = hi_q;
	assign status.count     = count_q;

endmodule

`default_nettype wire

// File: hw/rtl/roulette_wheel_selector.sv
// Top level of the roulette wheel selector: controller, prefix store and output register.
// Depends on rws_pkg, rws_store and rws_engine.
//
//   channel   signals                                   direction
//   req       req_valid req_stall kind fitness          in
//             random_fraction
//   rsp       rsp_valid rsp_stall selected_index        out
//             empty_error overflow_seen
//
// Clear, append and ignored kinds are taken in the idle state; a spin on a nonempty
// wheel passes the multiply state and then the binary search, with one store read and
// one compare per step; on an empty wheel it goes straight to the done state.
// Reset clears the count, the total and the overflow flag; store entries
// are written by appends before they are read. A finished result waits in the output
// register, and clears and appends are still taken while it waits.
`timescale 1ns / 1ps
`default_nettype none

module roulette_wheel_selector
	import rws_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_stall,
	input  wire logic [KIND_W-1:0] kind,
	input  wire logic [FIT_W-1:0]  fitness,
	input  wire logic [FRAC_W-1:0] random_fraction,
	output logic                   rsp_valid,
	input  wire logic              rsp_stall,
	output logic      [IDX_W-1:0]  selected_index,
	output logic                   empty_error,
	output logic                   overflow_seen
);

	logic             res_valid, res_stall;
	rws_result_t      res, out_q;
	rws_status_t      status;
	logic             wr_en, rd_en;
	logic [IDX_W-1:0] wr_addr, rd_addr;
	logic [SUM_W-1:0] wr_data, rd_data;
	logic             out_valid_q;

	rws_engine u_engine (
		.clk             (clk),
		.arst_n          (arst_n),
		.req_valid       (req_valid),
		.req_stall       (req_stall),
		.kind            (kind),
		.fitness         (fitness),
		.random_fraction (random_fraction),
		.res_valid       (res_valid),
		.res_stall       (res_stall),
		.res             (res),
		.status          (status),
		.wr_en           (wr_en),
		.wr_addr         (wr_addr),
		.wr_data         (wr_data),
		.rd_en           (rd_en),
		.rd_addr         (rd_addr),
		.rd_data         (rd_data)
	);

	rws_store u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign res_stall = out_valid_q && rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && !res_stall) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && !res_stall) begin
			out_q <= res;
		end
	end

	assign rsp_valid      = out_valid_q;
	assign selected_index = out_q.index;
	assign empty_error    = out_q.empty;
	assign overflow_seen  = out_q.overflow;

`ifndef ASSERT_OFF
	a_search_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		status.searching |-> (status.lo <= status.hi) && ({1'b0, status.hi} < status.count))
		else $error("search window out of the population");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		status.count <= CNT_W'(MAX_POP))
		else $error("population count beyond capacity");

	a_empty_index: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && empty_error |-> (selected_index == '0))
		else $error("empty spin returned a nonzero index");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		status.searching |-> req_stall)
		else $error("request taken during a spin");
`endif

endmodule

`default_nettype wire
